[design/date_difference_in_days_unit_defines.svh]
// assertion macros used by the checker file
`ifndef DATE_DIFFERENCE_IN_DAYS_UNIT_DEFINES_SVH
`define DATE_DIFFERENCE_IN_DAYS_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DDD_ASSERT_NOW(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("ddd check failed");

// next-cycle implication, disabled during reset
`define DDD_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("ddd check failed");

`endif

[design/ddd_pkg.sv]
`timescale 1ns / 1ps

package ddd_pkg;

   // field widths
   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int DOY_W   = 9;
   localparam int COUNT_W = 22;
   localparam int ACC_W   = 24;

   // largest year accepted as valid
   localparam int MAX_YEAR = 9999;
   localparam logic [15:0] YEAR_LIMIT = 16'(MAX_YEAR);

   // count saturation value
   localparam logic [ACC_W-1:0] COUNT_MAX = ACC_W'((1 << COUNT_W) - 1);

   // reciprocal of 100 for years below 2**14
   localparam logic [12:0] HUNDRED_RECIP = 13'd5243;
   localparam int RECIP_SHIFT = 19;

   // days in a common year
   localparam logic [ACC_W-1:0] COMMON_YEAR_DAYS = ACC_W'(365);

   // month numbers
   localparam logic [MONTH_W-1:0] JANUARY   = 4'd1;
   localparam logic [MONTH_W-1:0] FEBRUARY  = 4'd2;
   localparam logic [MONTH_W-1:0] MARCH     = 4'd3;
   localparam logic [MONTH_W-1:0] APRIL     = 4'd4;
   localparam logic [MONTH_W-1:0] MAY       = 4'd5;
   localparam logic [MONTH_W-1:0] JUNE      = 4'd6;
   localparam logic [MONTH_W-1:0] JULY      = 4'd7;
   localparam logic [MONTH_W-1:0] AUGUST    = 4'd8;
   localparam logic [MONTH_W-1:0] SEPTEMBER = 4'd9;
   localparam logic [MONTH_W-1:0] OCTOBER   = 4'd10;
   localparam logic [MONTH_W-1:0] NOVEMBER  = 4'd11;
   localparam logic [MONTH_W-1:0] DECEMBER  = 4'd12;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK_FIRST,
      ST_CHECK_SECOND,
      ST_ORDER,
      ST_YEARS,
      ST_FINISH
   } ddd_state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic check_first;
      logic check_second;
      logic order;
      logic step;
      logic emit;
   } ddd_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic invalid;
      logic year_done;
   } ddd_status_type;

   // gregorian leap test, century found by reciprocal multiply
   function automatic logic is_leap(input logic [YEAR_W-1:0] year);
      logic [26:0]       prod;
      logic [7:0]        cent;
      logic [YEAR_W-1:0] rem;
      prod = 27'(year) * 27'(HUNDRED_RECIP);
      cent = prod[26:RECIP_SHIFT];
      rem  = year - YEAR_W'(YEAR_W'(cent) * YEAR_W'(100));
      return ((year[1:0] == 2'b00) && (rem != '0)) ||
             ((rem == '0) && (cent[1:0] == 2'b00));
   endfunction

   // days in a month
   function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month,
                                                     input logic leap);
      logic [DAY_W-1:0] len;
      case (month)
         FEBRUARY:  len = leap ? 5'd29 : 5'd28;
         APRIL:     len = 5'd30;
         JUNE:      len = 5'd30;
         SEPTEMBER: len = 5'd30;
         NOVEMBER:  len = 5'd30;
         default:   len = 5'd31;
      endcase
      return len;
   endfunction

   // days of the year before the first of a month
   function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] month);
      logic [DOY_W-1:0] days;
      case (month)
         JANUARY:   days = 9'd0;
         FEBRUARY:  days = 9'd31;
         MARCH:     days = 9'd59;
         APRIL:     days = 9'd90;
         MAY:       days = 9'd120;
         JUNE:      days = 9'd151;
         JULY:      days = 9'd181;
         AUGUST:    days = 9'd212;
         SEPTEMBER: days = 9'd243;
         OCTOBER:   days = 9'd273;
         NOVEMBER:  days = 9'd304;
         DECEMBER:  days = 9'd334;
         default:   days = 9'd0;
      endcase
      return days;
   endfunction

endpackage

[design/ddd_ctrl.sv]
`timescale 1ns / 1ps

module ddd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output ddd_pkg::ddd_cmd_type    cmd,
   input  ddd_pkg::ddd_status_type status
);
   import ddd_pkg::*;

   ddd_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // state and result valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK_FIRST;
            end
         end
         ST_CHECK_FIRST: begin
            cmd.check_first = 1'b1;
            state_in        = ST_CHECK_SECOND;
         end
         ST_CHECK_SECOND: begin
            cmd.check_second = 1'b1;
            state_in         = ST_ORDER;
         end
         ST_ORDER: begin
            cmd.order = 1'b1;
            state_in  = status.invalid ? ST_FINISH : ST_YEARS;
         end
         ST_YEARS: begin
            if (status.year_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_FINISH: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

[design/ddd_datapath.sv]
`timescale 1ns / 1ps

module ddd_datapath (
   input  logic                          clock,
   input  ddd_pkg::ddd_cmd_type          cmd,
   output ddd_pkg::ddd_status_type       status,
   input  logic [ddd_pkg::DAY_W-1:0]     first_day,
   input  logic [ddd_pkg::MONTH_W-1:0]   first_month,
   input  logic [ddd_pkg::YEAR_W-1:0]    first_year,
   input  logic [ddd_pkg::DAY_W-1:0]     second_day,
   input  logic [ddd_pkg::MONTH_W-1:0]   second_month,
   input  logic [ddd_pkg::YEAR_W-1:0]    second_year,
   output logic [ddd_pkg::COUNT_W-1:0]   day_count,
   output logic                          date_invalid
);
   import ddd_pkg::*;

   logic [DAY_W-1:0]   first_day_ff, second_day_ff;
   logic [MONTH_W-1:0] first_month_ff, second_month_ff;
   logic [YEAR_W-1:0]  first_year_ff, second_year_ff;
   logic               valid_ff, valid_in;
   logic [DOY_W-1:0]   doy_first_ff, doy_second_ff, doy_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [YEAR_W-1:0]  cur_year_ff, cur_year_in;
   logic [YEAR_W-1:0]  end_year_ff, end_year_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               invalid_ff;

   logic [DAY_W-1:0]   chk_day;
   logic [MONTH_W-1:0] chk_month;
   logic [YEAR_W-1:0]  leap_year;
   logic               leap;
   logic               date_ok;
   logic               first_later;

   // shared leap unit: date under check, else the walking year
   always_comb begin
      chk_day   = second_day_ff;
      chk_month = second_month_ff;
      leap_year = cur_year_ff;
      if (cmd.check_first) begin
         chk_day   = first_day_ff;
         chk_month = first_month_ff;
         leap_year = first_year_ff;
      end else if (cmd.check_second) begin
         leap_year = second_year_ff;
      end
      leap = is_leap(leap_year);
   end

   // validity and day of year of the date under check
   always_comb begin
      date_ok = (leap_year != '0) && ({2'b00, leap_year} <= YEAR_LIMIT) &&
                (chk_month != '0) && (chk_month <= DECEMBER) &&
                (chk_day != '0) && (chk_day <= month_length(chk_month, leap));
      doy_in  = days_before(chk_month) + DOY_W'(chk_day) +
                DOY_W'((chk_month > FEBRUARY) && leap);
      valid_in = cmd.check_first ? date_ok : (valid_ff & date_ok);
   end

   // ordering, year walk and output selection
   always_comb begin
      first_later = {first_year_ff, first_month_ff, first_day_ff} >
                    {second_year_ff, second_month_ff, second_day_ff};
      acc_in      = acc_ff;
      cur_year_in = cur_year_ff;
      end_year_in = end_year_ff;
      if (cmd.order) begin
         if (first_later) begin
            acc_in      = ACC_W'(doy_first_ff) - ACC_W'(doy_second_ff);
            cur_year_in = second_year_ff;
            end_year_in = first_year_ff;
         end else begin
            acc_in      = ACC_W'(doy_second_ff) - ACC_W'(doy_first_ff);
            cur_year_in = first_year_ff;
            end_year_in = second_year_ff;
         end
      end else if (cmd.step) begin
         acc_in      = acc_ff + COMMON_YEAR_DAYS + ACC_W'(leap);
         cur_year_in = cur_year_ff + YEAR_W'(1);
      end
      if (!valid_ff) begin
         count_in = '0;
      end else if (acc_ff > COUNT_MAX) begin
         count_in = COUNT_MAX[COUNT_W-1:0];
      end else begin
         count_in = acc_ff[COUNT_W-1:0];
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         first_day_ff    <= first_day;
         first_month_ff  <= first_month;
         first_year_ff   <= first_year;
         second_day_ff   <= second_day;
         second_month_ff <= second_month;
         second_year_ff  <= second_year;
      end
      if (cmd.check_first) begin
         doy_first_ff <= doy_in;
      end
      if (cmd.check_second) begin
         doy_second_ff <= doy_in;
      end
      if (cmd.check_first || cmd.check_second) begin
         valid_ff <= valid_in;
      end
      acc_ff      <= acc_in;
      cur_year_ff <= cur_year_in;
      end_year_ff <= end_year_in;
      if (cmd.emit) begin
         count_ff   <= count_in;
         invalid_ff <= !valid_ff;
      end
   end

   assign status.invalid   = !valid_ff;
   assign status.year_done = (cur_year_ff == end_year_ff);
   assign day_count        = count_ff;
   assign date_invalid     = invalid_ff;

endmodule

[design/date_difference_in_days_unit.sv]
`timescale 1ns / 1ps
// channel   direction  handshake               payload
// req       in         req_tvalid/req_tready   two dates in req_tdata
// rsp       out        rsp_tvalid/rsp_tready   day count in rsp_tdata, flag in rsp_tuser
//
// one item at a time: after the date checks and ordering, a year walk adds one year length
// per cycle through one leap unit, from the earlier date's year up to the later one.
// an invalid date skips the walk.
// reset is synchronous and active high; it clears the sequencer and the result valid.
// a result waiting on rsp_tready does not block accepting the next item; that item
// finishes its work and then holds until the output register is free.

module date_difference_in_days_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // first_day[4:0], first_month[8:5], first_year[22:9],
   // second_day[27:23], second_month[31:28], second_year[45:32], zeros[47:46]
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // day_count[21:0], zeros[23:22]
   output logic [23:0] rsp_tdata,
   // date_invalid[0]
   output logic [0:0]  rsp_tuser
);
   import ddd_pkg::*;

   ddd_cmd_type        cmd;
   ddd_status_type     status;
   logic [COUNT_W-1:0] day_count;
   logic               date_invalid;

   // sequencer
   ddd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   // date checks, year walk and result register
   ddd_datapath u_datapath (
      .clock        (clock),
      .cmd          (cmd),
      .status       (status),
      .first_day    (req_tdata[4:0]),
      .first_month  (req_tdata[8:5]),
      .first_year   (req_tdata[22:9]),
      .second_day   (req_tdata[27:23]),
      .second_month (req_tdata[31:28]),
      .second_year  (req_tdata[45:32]),
      .day_count    (day_count),
      .date_invalid (date_invalid)
   );

   // result packing
   assign rsp_tdata = {2'b00, day_count};
   assign rsp_tuser = date_invalid;

endmodule

[design/ddd_checker.sv]
`timescale 1ns / 1ps
`include "date_difference_in_days_unit_defines.svh"

module ddd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   // a stalled result holds
   `DDD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // an invalid date gives a zero count
   `DDD_ASSERT_NOW(a_invalid_zero, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata == 24'd0)

   // one transaction at a time on the input side
   `DDD_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready)

   // a result never appears right after an accept
   `DDD_ASSERT_NEXT(a_no_instant_rsp, clock, reset, req_tvalid && req_tready, !$rose(rsp_tvalid))

endmodule

bind date_difference_in_days_unit ddd_checker u_checker (.*);
